[rtl/rpa_pkg.sv]
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared widths, constants and control/status types of the PR-area unit.
// ----------------------------------------------------------------------------
package rpa_pkg;

    localparam int DEPTH   = 1024;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = AW + 1;
    localparam int SCORE_W = 32;
    localparam int PAIR_W  = SCORE_W + 1;
    localparam int LABEL_W = 8;
    localparam int WS_W    = 11;
    localparam int AUC_W   = 17;
    localparam int PREC_W  = 33;
    localparam int MULB_W  = 34;
    localparam int PROD_W  = 45;
    localparam int SUM_W   = 45;
    localparam int DIV_N   = 45;
    localparam int DIV_D   = 28;
    localparam int DIV_CW  = 6;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [AUC_W-1:0]  AUC_MAX = AUC_W'(65536);
    localparam logic [MULB_W-1:0] ONE_Q32 = MULB_W'(64'h1_0000_0000);
    localparam logic [CW-1:0]     DEPTH_C = CW'(DEPTH);

    localparam logic REG_POS_LABEL   = 1'b0;
    localparam logic REG_WINDOW_SIZE = 1'b1;

    typedef struct packed {
        logic accept;
        logic arr_rd;
        logic ev_get;
        logic srt_rd;
        logic srt_prev;
        logic rm_step;
        logic rm_end;
        logic ins_arr;
        logic ins_shift;
        logic ins_place;
        logic rv_step;
        logic rv_hit;
        logic ar_zero;
        logic ar_init;
        logic div_start;
        logic div_final;
        logic ar_prev;
        logic ar_new;
        logic ar_prec;
        logic ar_mul;
        logic ar_close;
        logic ar_acc;
        logic ar_dec;
        logic auc_load;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic evict_needed;
        logic idx_at_count;
        logic idx_zero;
        logic found;
        logic srt_gt;
        logic count_full;
        logic single_class;
        logic new_score;
        logic tpfp_zero;
        logic div_busy;
    } t_stat;

endpackage

[rtl/rpa_div.sv]
// ----------------------------------------------------------------------------
// rpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpa_pkg::DIV_N-1:0]  i_dividend,
    input  logic [rpa_pkg::DIV_D-1:0]  i_divisor,
    output logic                       o_busy,
    output logic [rpa_pkg::DIV_N-1:0]  o_quotient
);

    logic                       r_busy;
    logic [rpa_pkg::DIV_CW-1:0] r_cnt;
    logic [rpa_pkg::DIV_D-1:0]  r_rem;
    logic [rpa_pkg::DIV_D-1:0]  r_dvs;
    logic [rpa_pkg::DIV_N-1:0]  r_quo;
    logic [rpa_pkg::DIV_D:0]    w_trial;
    logic [rpa_pkg::DIV_D:0]    w_diff;
    logic                       w_ge;

    assign w_trial = {r_rem, r_quo[rpa_pkg::DIV_N-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == rpa_pkg::DIV_CW'(rpa_pkg::DIV_N - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[rpa_pkg::DIV_D-1:0] : w_trial[rpa_pkg::DIV_D-1:0];
            r_quo <= {r_quo[rpa_pkg::DIV_N-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[rtl/rpa_datapath.sv]
// ----------------------------------------------------------------------------
// rpa_datapath
// Window stores, counters and the PR-area accumulator.
// ----------------------------------------------------------------------------
module rpa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rpa_pkg::t_cmd                 i_cmd,
    output rpa_pkg::t_stat                o_stat,
    input  logic                          i_kind,
    input  logic [rpa_pkg::LABEL_W-1:0]   i_label,
    input  logic [rpa_pkg::SCORE_W-1:0]   i_score,
    input  logic [rpa_pkg::LABEL_W-1:0]   i_pos_label,
    input  logic [rpa_pkg::WS_W-1:0]      i_win_size,
    output logic [rpa_pkg::AUC_W-1:0]     o_auc,
    output logic [rpa_pkg::CW-1:0]        o_positive_count,
    output logic [rpa_pkg::CW-1:0]        o_window_count,
    output logic                          o_matched
);

    logic [rpa_pkg::PAIR_W-1:0] r_arr_mem [0:rpa_pkg::DEPTH-1];
    logic [rpa_pkg::PAIR_W-1:0] r_srt_mem [0:rpa_pkg::DEPTH-1];

    logic [rpa_pkg::PAIR_W-1:0]  r_ard, r_srd, r_e, r_key;
    logic                        r_kind, r_found, r_matched, r_have;
    logic [rpa_pkg::AW-1:0]      r_oldest;
    logic [rpa_pkg::CW-1:0]      r_count, r_pos, r_idx;
    logic [rpa_pkg::CW-1:0]      r_tp, r_fp, r_tpp;
    logic [rpa_pkg::PREC_W-1:0]  r_prec, r_prec_prev;
    logic [rpa_pkg::SCORE_W-1:0] r_last;
    logic [rpa_pkg::SUM_W-1:0]   r_sum;
    logic [rpa_pkg::PROD_W-1:0]  r_prod;
    logic [rpa_pkg::AUC_W-1:0]   r_auc;

    logic [rpa_pkg::CW-1:0]      w_idx_m1, w_limit, w_tpfp, w_ma;
    logic [rpa_pkg::AW-1:0]      w_arr_ra, w_arr_wa, w_srt_ra, w_srt_wa;
    logic [rpa_pkg::PAIR_W-1:0]  w_arr_wd, w_srt_wd;
    logic                        w_arr_we, w_srt_we;
    logic [rpa_pkg::MULB_W-1:0]  w_mb;
    logic [rpa_pkg::DIV_N-1:0]   w_dividend, w_q;
    logic [rpa_pkg::DIV_D-1:0]   w_divisor;
    logic                        w_div_busy;
    logic [rpa_pkg::PREC_W-1:0]  w_qp;

    assign w_idx_m1 = r_idx - 1'b1;
    assign w_limit  = (i_win_size > rpa_pkg::DEPTH_C) ? rpa_pkg::DEPTH_C : i_win_size;
    assign w_tpfp   = r_tp + r_fp;

    assign w_arr_ra = r_oldest + r_idx[rpa_pkg::AW-1:0];
    assign w_arr_we = i_cmd.ins_arr || (i_cmd.rv_step && r_found);
    assign w_arr_wa = i_cmd.ins_arr ? r_oldest + r_count[rpa_pkg::AW-1:0]
                                    : r_oldest + w_idx_m1[rpa_pkg::AW-1:0];
    assign w_arr_wd = i_cmd.ins_arr ? r_e : r_ard;

    assign w_srt_ra = i_cmd.srt_prev ? w_idx_m1[rpa_pkg::AW-1:0] : r_idx[rpa_pkg::AW-1:0];
    assign w_srt_we = (i_cmd.rm_step && r_found) || i_cmd.ins_shift || i_cmd.ins_place;
    assign w_srt_wa = i_cmd.rm_step ? w_idx_m1[rpa_pkg::AW-1:0] : r_idx[rpa_pkg::AW-1:0];
    assign w_srt_wd = i_cmd.ins_place ? r_e : r_srd;

    always_ff @(posedge i_clk) begin
        if (w_arr_we) begin
            r_arr_mem[w_arr_wa] <= w_arr_wd;
        end
        if (i_cmd.arr_rd) begin
            r_ard <= r_arr_mem[w_arr_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_srt_we) begin
            r_srt_mem[w_srt_wa] <= w_srt_wd;
        end
        if (i_cmd.srt_rd) begin
            r_srd <= r_srt_mem[w_srt_ra];
        end
    end

    // window bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest <= '0;
            r_count  <= '0;
            r_pos    <= '0;
        end else begin
            if (i_cmd.ev_get && r_ard[0] && r_pos != '0) begin
                r_pos <= r_pos - 1'b1;
            end
            if (i_cmd.rv_hit && r_e[0] && r_pos != '0) begin
                r_pos <= r_pos - 1'b1;
            end
            if (i_cmd.rm_end) begin
                r_count <= r_count - 1'b1;
                if (!r_kind) begin
                    r_oldest <= r_oldest + 1'b1;
                end
            end
            if (i_cmd.ins_place) begin
                r_count <= r_count + 1'b1;
                r_pos   <= r_pos + rpa_pkg::CW'(r_e[0]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_e       <= {i_score, (i_label == i_pos_label)};
            r_key     <= {i_score, (i_label == i_pos_label)};
            r_kind    <= i_kind;
            r_matched <= 1'b0;
        end
        if (i_cmd.ev_get) begin
            r_key <= r_ard;
        end
        if (i_cmd.rv_hit) begin
            r_matched <= 1'b1;
        end

        if (i_cmd.accept || i_cmd.rv_hit || i_cmd.ar_init) begin
            r_idx <= '0;
        end else if (i_cmd.ins_arr) begin
            r_idx <= r_count;
        end else if (i_cmd.ins_shift) begin
            r_idx <= w_idx_m1;
        end else if (i_cmd.rm_step || i_cmd.rv_step || i_cmd.ar_dec) begin
            r_idx <= r_idx + 1'b1;
        end

        if (i_cmd.accept || i_cmd.rv_hit) begin
            r_found <= 1'b0;
        end else if (i_cmd.rm_step && r_srd == r_key) begin
            r_found <= 1'b1;
        end else if (i_cmd.rv_step && r_ard == r_e) begin
            r_found <= 1'b1;
        end
    end

    // precision-recall walk
    assign w_qp = w_q[rpa_pkg::PREC_W-1:0];
    assign w_ma = r_tpp - r_tp;
    assign w_mb = i_cmd.ar_close ? rpa_pkg::ONE_Q32 + {1'b0, r_prec_prev}
                                 : {1'b0, r_prec} + {1'b0, r_prec_prev};

    assign w_dividend = i_cmd.div_final
                      ? r_sum + rpa_pkg::SUM_W'({r_pos, 16'b0})
                      : rpa_pkg::DIV_N'({r_tp, 32'b0});
    assign w_divisor  = i_cmd.div_final ? rpa_pkg::DIV_D'({r_pos, 17'b0})
                                        : rpa_pkg::DIV_D'(w_tpfp);

    rpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.ar_init) begin
            r_tp   <= r_pos;
            r_fp   <= r_count - r_pos;
            r_tpp  <= r_pos;
            r_sum  <= '0;
            r_have <= 1'b0;
        end
        if (i_cmd.ar_prev) begin
            r_prec_prev <= w_qp;
        end
        if (i_cmd.ar_new) begin
            r_last <= r_srd[rpa_pkg::PAIR_W-1:1];
            r_have <= 1'b1;
        end
        if (i_cmd.ar_prec) begin
            r_prec <= (w_qp < r_prec_prev) ? r_prec_prev : w_qp;
        end
        if (i_cmd.ar_mul) begin
            r_prod <= rpa_pkg::PROD_W'(w_ma) * rpa_pkg::PROD_W'(w_mb);
        end
        if (i_cmd.ar_acc) begin
            r_sum       <= r_sum + r_prod;
            r_tpp       <= r_tp;
            r_prec_prev <= r_prec;
        end
        if (i_cmd.ar_dec) begin
            if (r_srd[0]) begin
                if (r_tp != '0) begin
                    r_tp <= r_tp - 1'b1;
                end
            end else begin
                if (r_fp != '0) begin
                    r_fp <= r_fp - 1'b1;
                end
            end
        end
        if (i_cmd.ar_zero) begin
            r_auc <= '0;
        end else if (i_cmd.auc_load) begin
            r_auc <= (w_q > rpa_pkg::DIV_N'(rpa_pkg::AUC_MAX)) ? rpa_pkg::AUC_MAX
                                                                : w_q[rpa_pkg::AUC_W-1:0];
        end
        if (i_cmd.out_load) begin
            o_auc            <= r_auc;
            o_positive_count <= r_pos;
            o_window_count   <= r_count;
            o_matched        <= r_matched;
        end
    end

    assign o_stat.kind         = r_kind;
    assign o_stat.evict_needed = (r_count != '0) && (r_count >= w_limit);
    assign o_stat.idx_at_count = (r_idx == r_count);
    assign o_stat.idx_zero     = (r_idx == '0);
    assign o_stat.found        = r_found;
    assign o_stat.srt_gt       = (r_srd > r_e);
    assign o_stat.count_full   = (r_count == rpa_pkg::DEPTH_C);
    assign o_stat.single_class = (r_pos == '0) || (r_pos >= r_count);
    assign o_stat.new_score    = !r_have || (r_srd[rpa_pkg::PAIR_W-1:1] != r_last);
    assign o_stat.tpfp_zero    = (w_tpfp == '0);
    assign o_stat.div_busy     = w_div_busy;

endmodule

[rtl/rpa_ctrl.sv]
// ----------------------------------------------------------------------------
// rpa_ctrl
// Sequencer for evict, insert, revert and the PR-area walk.
// ----------------------------------------------------------------------------
module rpa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  rpa_pkg::t_stat i_stat,
    output rpa_pkg::t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_EV_RD    = 5'd2;
    localparam logic [4:0] S_EV_GET   = 5'd3;
    localparam logic [4:0] S_RM_RD    = 5'd4;
    localparam logic [4:0] S_RM_CMP   = 5'd5;
    localparam logic [4:0] S_RM_END   = 5'd6;
    localparam logic [4:0] S_INS_ARR  = 5'd7;
    localparam logic [4:0] S_INS_RD   = 5'd8;
    localparam logic [4:0] S_INS_CMP  = 5'd9;
    localparam logic [4:0] S_RV_RD    = 5'd10;
    localparam logic [4:0] S_RV_CMP   = 5'd11;
    localparam logic [4:0] S_AR_INIT  = 5'd12;
    localparam logic [4:0] S_AR_PDIV  = 5'd13;
    localparam logic [4:0] S_AR_PWAIT = 5'd14;
    localparam logic [4:0] S_AR_RD    = 5'd15;
    localparam logic [4:0] S_AR_CMP   = 5'd16;
    localparam logic [4:0] S_AR_DWAIT = 5'd17;
    localparam logic [4:0] S_AR_MUL   = 5'd18;
    localparam logic [4:0] S_AR_ACC   = 5'd19;
    localparam logic [4:0] S_AR_CMUL  = 5'd20;
    localparam logic [4:0] S_AR_CACC  = 5'd21;
    localparam logic [4:0] S_AR_FDIV  = 5'd22;
    localparam logic [4:0] S_AR_FWAIT = 5'd23;
    localparam logic [4:0] S_DONE     = 5'd24;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.kind) begin
                    n_state = S_RV_RD;
                end else if (i_stat.evict_needed) begin
                    n_state = S_EV_RD;
                end else begin
                    n_state = S_INS_ARR;
                end
            end
            S_EV_RD: begin
                o_cmd.arr_rd = 1'b1;
                n_state      = S_EV_GET;
            end
            S_EV_GET: begin
                o_cmd.ev_get = 1'b1;
                n_state      = S_RM_RD;
            end
            S_RM_RD: begin
                if (i_stat.idx_at_count) begin
                    n_state = S_RM_END;
                end else begin
                    o_cmd.srt_rd = 1'b1;
                    n_state      = S_RM_CMP;
                end
            end
            S_RM_CMP: begin
                o_cmd.rm_step = 1'b1;
                n_state       = S_RM_RD;
            end
            S_RM_END: begin
                o_cmd.rm_end = 1'b1;
                n_state      = i_stat.kind ? S_AR_INIT : S_INS_ARR;
            end
            S_INS_ARR: begin
                if (i_stat.count_full) begin
                    n_state = S_AR_INIT;
                end else begin
                    o_cmd.ins_arr = 1'b1;
                    n_state       = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (i_stat.idx_zero) begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_AR_INIT;
                end else begin
                    o_cmd.srt_rd   = 1'b1;
                    o_cmd.srt_prev = 1'b1;
                    n_state        = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.srt_gt) begin
                    o_cmd.ins_shift = 1'b1;
                    n_state         = S_INS_RD;
                end else begin
                    o_cmd.ins_place = 1'b1;
                    n_state         = S_AR_INIT;
                end
            end
            S_RV_RD: begin
                if (i_stat.idx_at_count) begin
                    if (i_stat.found) begin
                        o_cmd.rv_hit = 1'b1;
                        n_state      = S_RM_RD;
                    end else begin
                        n_state = S_AR_INIT;
                    end
                end else begin
                    o_cmd.arr_rd = 1'b1;
                    n_state      = S_RV_CMP;
                end
            end
            S_RV_CMP: begin
                o_cmd.rv_step = 1'b1;
                n_state       = S_RV_RD;
            end
            S_AR_INIT: begin
                if (i_stat.single_class) begin
                    o_cmd.ar_zero = 1'b1;
                    n_state       = S_DONE;
                end else begin
                    o_cmd.ar_init = 1'b1;
                    n_state       = S_AR_PDIV;
                end
            end
            S_AR_PDIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_AR_PWAIT;
            end
            S_AR_PWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.ar_prev = 1'b1;
                    n_state       = S_AR_RD;
                end
            end
            S_AR_RD: begin
                if (i_stat.idx_at_count) begin
                    n_state = S_AR_CMUL;
                end else begin
                    o_cmd.srt_rd = 1'b1;
                    n_state      = S_AR_CMP;
                end
            end
            S_AR_CMP: begin
                if (i_stat.new_score && !i_stat.tpfp_zero) begin
                    o_cmd.ar_new    = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_AR_DWAIT;
                end else begin
                    o_cmd.ar_new = i_stat.new_score;
                    o_cmd.ar_dec = 1'b1;
                    n_state      = S_AR_RD;
                end
            end
            S_AR_DWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.ar_prec = 1'b1;
                    n_state       = S_AR_MUL;
                end
            end
            S_AR_MUL: begin
                o_cmd.ar_mul = 1'b1;
                n_state      = S_AR_ACC;
            end
            S_AR_ACC: begin
                o_cmd.ar_acc = 1'b1;
                o_cmd.ar_dec = 1'b1;
                n_state      = S_AR_RD;
            end
            S_AR_CMUL: begin
                o_cmd.ar_mul   = 1'b1;
                o_cmd.ar_close = 1'b1;
                n_state        = S_AR_CACC;
            end
            S_AR_CACC: begin
                o_cmd.ar_acc = 1'b1;
                n_state      = S_AR_FDIV;
            end
            S_AR_FDIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_final = 1'b1;
                n_state         = S_AR_FWAIT;
            end
            S_AR_FWAIT: begin
                if (!i_stat.div_busy) begin
                    o_cmd.auc_load = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;

endmodule

[rtl/rolling_pr_auc_unit.sv]
// ----------------------------------------------------------------------------
// rolling_pr_auc_unit
// Sliding-window precision-recall area over (score, label) words.
// ----------------------------------------------------------------------------
// One word is processed at a time. The arrival and sorted stores are
// single-port memories walked one entry at a time, with a read state and a
// compare state per entry (evict/revert scan, sorted insert, area walk), and
// each distinct score costs at most one pass of the bit-serial divider. A
// finished result sits in the output register while the next word is
// accepted. No clearing pass after reset.
module rolling_pr_auc_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic [rpa_pkg::LABEL_W-1:0]       i_label,
    input  logic [rpa_pkg::SCORE_W-1:0]       i_score,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [rpa_pkg::AUC_W-1:0]         o_auc,
    output logic [rpa_pkg::CW-1:0]            o_positive_count,
    output logic [rpa_pkg::CW-1:0]            o_window_count,
    output logic                              o_matched,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rpa_pkg::ADDR_W-1:0]        paddr,
    input  logic [rpa_pkg::DATA_W-1:0]        pwdata,
    output logic [rpa_pkg::DATA_W-1:0]        prdata,
    output logic                              pready
);

    logic [rpa_pkg::LABEL_W-1:0] r_pos_label;
    logic [rpa_pkg::WS_W-1:0]    r_win_size;
    rpa_pkg::t_cmd               w_cmd;
    rpa_pkg::t_stat              w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_label <= rpa_pkg::LABEL_W'(1);
            r_win_size  <= rpa_pkg::WS_W'(1000);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                rpa_pkg::REG_POS_LABEL: begin
                    r_pos_label <= pwdata[rpa_pkg::LABEL_W-1:0];
                end
                rpa_pkg::REG_WINDOW_SIZE: begin
                    r_win_size <= pwdata[rpa_pkg::WS_W-1:0];
                end
                default: begin
                    r_win_size <= r_win_size;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            rpa_pkg::REG_POS_LABEL:   prdata = rpa_pkg::DATA_W'(r_pos_label);
            rpa_pkg::REG_WINDOW_SIZE: prdata = rpa_pkg::DATA_W'(r_win_size);
            default:                  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    rpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    rpa_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_kind           (i_kind),
        .i_label          (i_label),
        .i_score          (i_score),
        .i_pos_label      (r_pos_label),
        .i_win_size       (r_win_size),
        .o_auc            (o_auc),
        .o_positive_count (o_positive_count),
        .o_window_count   (o_window_count),
        .o_matched        (o_matched)
    );

endmodule

[rtl/rpa_checker.sv]
// ----------------------------------------------------------------------------
// rpa_checker
// Port-level checks for the PR-area unit, bound to the top level.
// ----------------------------------------------------------------------------
module rpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic [rpa_pkg::AUC_W-1:0]   o_auc,
    input logic [rpa_pkg::CW-1:0]      o_positive_count,
    input logic [rpa_pkg::CW-1:0]      o_window_count,
    input logic                        o_matched
);

    a_auc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_auc <= rpa_pkg::AUC_MAX)
        else $error("auc above 1.0");

    a_pos_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_positive_count <= o_window_count)
        else $error("positive count exceeds window count");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_window_count <= rpa_pkg::DEPTH_C)
        else $error("window count above depth");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_auc) && $stable(o_matched))
        else $error("stalled result word changed");

endmodule

bind rolling_pr_auc_unit rpa_checker u_rpa_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_auc            (o_auc),
    .o_positive_count (o_positive_count),
    .o_window_count   (o_window_count),
    .o_matched        (o_matched)
);
